>>> src/sdsr_pkg.sv
// constants, types and command codes of the sd card spi mode responder
// no dependencies; imported by the top level
`default_nettype none

package sdsr_pkg;

	// block store geometry
	localparam int unsigned STORE_BYTES = 1048576;
	localparam int unsigned BLOCK_BYTES = 512;
	localparam int unsigned STORE_AW    = $clog2(STORE_BYTES);
	localparam int unsigned OFFS_W      = $clog2(BLOCK_BYTES);
	localparam int unsigned BLK_W       = STORE_AW - OFFS_W;
	localparam logic [31:0] BLOCK_COUNT = 32'(STORE_BYTES / BLOCK_BYTES);

	// byte position within one exchange
	localparam int unsigned POS_W = 10;
	typedef logic [POS_W-1:0] pos_t;

	localparam pos_t POS_FRAME_END = pos_t'(7);
	localparam pos_t POS_R1        = pos_t'(7);
	localparam pos_t POS_SECOND    = pos_t'(8);
	localparam pos_t POS_THIRD     = pos_t'(9);
	localparam pos_t POS_FOURTH    = pos_t'(10);
	localparam pos_t POS_FIFTH     = pos_t'(11);
	localparam pos_t POS_ECHO_END  = pos_t'(12);
	localparam pos_t POS_DATA      = pos_t'(10);
	localparam pos_t POS_DATA_END  = pos_t'(10 + BLOCK_BYTES);
	localparam pos_t POS_READ_END  = pos_t'(12 + BLOCK_BYTES);
	localparam pos_t K_CRC1        = pos_t'(BLOCK_BYTES);
	localparam pos_t K_CRC2        = pos_t'(BLOCK_BYTES + 1);
	localparam pos_t K_BUSY_END    = pos_t'(BLOCK_BYTES + 4);

	// card mode
	typedef enum logic [1:0] {
		MODE_POWERUP = 2'd0,
		MODE_IDLE    = 2'd1,
		MODE_READY   = 2'd2
	} card_mode_t;

	// command indexes
	localparam logic [5:0] CMD_GO_IDLE     = 6'd0;
	localparam logic [5:0] CMD_IF_COND     = 6'd8;
	localparam logic [5:0] CMD_READ_BLOCK  = 6'd17;
	localparam logic [5:0] CMD_WRITE_BLOCK = 6'd24;
	localparam logic [5:0] CMD_OP_COND     = 6'd41;
	localparam logic [5:0] CMD_APP         = 6'd55;
	localparam logic [5:0] CMD_READ_OCR    = 6'd58;

	// answer bytes
	localparam logic [7:0] BYTE_IDLE     = 8'hff;
	localparam logic [7:0] TOKEN_START   = 8'hfe;
	localparam logic [7:0] DATA_ACCEPTED = 8'he5;
	localparam logic [7:0] OCR_POWERED   = 8'hc0;
	localparam logic [7:0] OCR_VOLTAGE   = 8'h80;
	localparam logic [7:0] BYTE_ZERO     = 8'h00;
	localparam logic [7:0] R1_IDLE       = 8'h01;
	localparam logic [7:0] R1_ILLEGAL    = 8'h04;
	localparam logic [7:0] R1_PARAM      = 8'h40;

	// command frames, byte 0 in the low lane
	typedef logic [5:0][7:0] frame_t;
	localparam frame_t FRAME_GO_IDLE = {8'h95, 8'h00, 8'h00, 8'h00, 8'h00, 8'h40};
	localparam frame_t FRAME_IF_COND = {8'hd5, 8'h00, 8'h01, 8'h00, 8'h00, 8'h48};
	localparam frame_t FRAME_APP     = {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h77};
	localparam frame_t FRAME_OP_COND = {8'h00, 8'h00, 8'h00, 8'h00, 8'h40, 8'h69};

	// configuration port
	localparam int unsigned PADDR_W = 3;
	localparam logic [PADDR_W-1:0] REG_READY_DELAY = 3'd0;
	localparam logic [3:0] READY_DELAY_RESET = 4'd2;

endpackage

`default_nettype wire

>>> src/sdsr_if.sv
// byte channel interfaces of the responder: host byte in, card byte out
// no dependencies
`default_nettype none

interface sdsr_mosi_if;
	logic       valid;
	logic       ready;
	logic [7:0] mosi_byte;

	modport source (output valid, output mosi_byte, input ready);
	modport sink (input valid, input mosi_byte, output ready);
endinterface

interface sdsr_miso_if;
	logic       valid;
	logic       ready;
	logic [7:0] miso_byte;

	modport source (output valid, output miso_byte, input ready);
	modport sink (input valid, input miso_byte, output ready);
endinterface

`default_nettype wire

>>> src/sd_card_spi_mode_responder_unit.sv
// top level of the sd card spi mode responder: command decode and block store
// depends on sdsr_pkg, sdsr_if (sdsr_mosi_if, sdsr_miso_if) and sdsr_ram
//
//  channel  dir  handshake            payload
//  mosi     in   valid / ready        mosi_byte, host byte of one exchange
//  miso     out  valid / ready        miso_byte, card answer byte
//  apb      in   psel/penable/pready  ready_delay at byte address 0
//
// one byte is taken every cycle while mosi.ready is high; its answer passes the
// s1 stage (resp_s1 or the registered read of the block store ram) and byte_s2
// after reset the block store is swept to zero, one byte a cycle, over all
// STORE_BYTES (1048576) bytes; mosi.ready stays low during the sweep
// a stalled miso holds the answer in an output register and one more byte
// in the ram stage, after which mosi.ready drops
`default_nettype none

module sd_card_spi_mode_responder_unit
	import sdsr_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [31:0]        pwdata,
	output      logic [31:0]        prdata,
	output      logic               pready,
	sdsr_mosi_if.sink               mosi,
	sdsr_miso_if.source             miso
);

	// control state
	logic [3:0]    ready_delay_q;
	logic [3:0]    countdown_q, countdown_n;
	card_mode_t    mode_q, mode_n;
	pos_t          pos_q, pos_n;
	logic          app_q, app_n;
	logic          wts_q, wts_n;
	frame_t        frame_q, frame_n;

	// clearing sweep
	logic                clr_q;
	logic [STORE_AW-1:0] clr_addr_q;

	// pipeline
	logic       valid_s1, mem_s1;
	logic [7:0] resp_s1;
	logic       valid_s2;
	logic [7:0] byte_s2;

	// decode outputs
	logic [7:0]          b;
	logic [7:0]          r1;
	logic [7:0]          resp;
	logic                mem_rd, mem_wr;
	frame_t              frame_c;
	pos_t                p, k;
	logic [2:0]          echo_idx;
	logic [31:0]         blk;
	logic                blk_ok;
	logic [STORE_AW-1:0] addr;
	logic [7:0]          rd_data;
	logic                acc, adv1, cfg_wr;

	// handshakes
	assign adv1       = valid_s1 && (!valid_s2 || miso.ready);
	assign mosi.ready = !clr_q && (!valid_s1 || adv1);
	assign acc        = mosi.valid && mosi.ready;
	assign miso.valid     = valid_s2;
	assign miso.miso_byte = byte_s2;
	assign b = mosi.mosi_byte;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr == REG_READY_DELAY);
	assign prdata = (paddr == REG_READY_DELAY) ? {28'd0, ready_delay_q} : 32'd0;

	// frame with the current byte folded in, and derived fields
	always_comb begin
		frame_c = frame_q;
		if (pos_q < pos_t'(6)) begin
			frame_c[pos_q[2:0]] = b;
		end
	end

	assign p        = pos_t'(pos_q + 1'b1);
	assign k        = pos_t'(p - POS_DATA);
	assign echo_idx = 3'(p - POS_R1);
	assign blk      = {frame_c[1], frame_c[2], frame_c[3], frame_c[4]};
	assign blk_ok   = blk < BLOCK_COUNT;
	assign addr     = {blk[BLK_W-1:0], k[OFFS_W-1:0]};
	assign r1       = (mode_q == MODE_IDLE) ? R1_IDLE : BYTE_ZERO;

	// command decode and next state
	always_comb begin
		pos_n       = pos_q;
		frame_n     = frame_q;
		mode_n      = mode_q;
		app_n       = app_q;
		countdown_n = countdown_q;
		wts_n       = wts_q;
		resp        = BYTE_IDLE;
		mem_rd      = 1'b0;
		mem_wr      = 1'b0;
		priority if (pos_q == '0 && b == BYTE_IDLE) begin
			// idle fill between frames
		end else if (p < POS_FRAME_END) begin
			frame_n = frame_c;
			pos_n   = p;
		end else begin
			frame_n = frame_c;
			pos_n   = p;
			if (p == POS_R1) begin
				app_n = 1'b0;
			end
			if (frame_c[0][7:6] != 2'b01) begin
				pos_n = '0;
			end else begin
				unique case (frame_c[0][5:0])
					CMD_GO_IDLE: begin
						pos_n = '0;
						if (app_q) begin
							resp = r1 | R1_ILLEGAL;
						end else if (frame_c == FRAME_GO_IDLE) begin
							mode_n = MODE_IDLE;
							resp   = R1_IDLE;
						end
					end
					CMD_IF_COND: begin
						if (p == POS_R1) begin
							if (frame_c == FRAME_IF_COND) begin
								resp = r1;
							end else begin
								pos_n = '0;
							end
						end else if (p < POS_ECHO_END) begin
							resp = frame_c[echo_idx];
						end else begin
							pos_n = '0;
						end
					end
					CMD_APP: begin
						pos_n = '0;
						if (frame_c[4:0] == FRAME_APP[4:0]) begin
							app_n = 1'b1;
							resp  = r1;
						end
					end
					CMD_OP_COND: begin
						pos_n = '0;
						if (!app_q) begin
							resp = r1 | R1_ILLEGAL;
						end else if (frame_c[4:0] == FRAME_OP_COND[4:0]) begin
							if (countdown_q == 4'd0) begin
								mode_n = MODE_READY;
								resp   = BYTE_ZERO;
							end else begin
								countdown_n = countdown_q - 4'd1;
								resp        = r1;
							end
						end
					end
					CMD_READ_OCR: begin
						priority if (p == POS_R1) begin
							resp = r1;
						end else if (p == POS_SECOND) begin
							resp = (mode_q == MODE_IDLE) ? BYTE_ZERO : OCR_POWERED;
						end else if (p == POS_THIRD) begin
							resp = BYTE_IDLE;
						end else if (p == POS_FOURTH) begin
							resp = OCR_VOLTAGE;
						end else if (p == POS_FIFTH) begin
							resp = BYTE_ZERO;
						end else begin
							pos_n = '0;
						end
					end
					CMD_READ_BLOCK: begin
						priority if (p == POS_R1) begin
							if (blk_ok) begin
								resp = r1;
							end else begin
								pos_n = '0;
								resp  = r1 | R1_PARAM;
							end
						end else if (p == POS_SECOND) begin
							resp = BYTE_IDLE;
						end else if (p == POS_THIRD) begin
							resp = TOKEN_START;
						end else if (p < POS_DATA_END) begin
							mem_rd = 1'b1;
						end else if (p >= POS_READ_END) begin
							pos_n = '0;
						end else begin
							// crc bytes of the block
							resp = BYTE_IDLE;
						end
					end
					CMD_WRITE_BLOCK: begin
						priority if (p == POS_R1) begin
							wts_n = 1'b0;
							if (blk_ok) begin
								resp = r1;
							end else begin
								pos_n = '0;
								resp  = r1 | R1_PARAM;
							end
						end else if (p == POS_SECOND) begin
							resp = BYTE_IDLE;
						end else if (!wts_q) begin
							// wait for the start token; position holds
							if (b == TOKEN_START) begin
								wts_n = 1'b1;
							end else begin
								pos_n = pos_q;
							end
						end else if (k < K_CRC1) begin
							mem_wr = 1'b1;
						end else if (k == K_CRC1) begin
							resp = BYTE_IDLE;
						end else if (k == K_CRC2) begin
							resp = DATA_ACCEPTED;
						end else if (k < K_BUSY_END) begin
							resp = BYTE_ZERO;
						end else begin
							pos_n = '0;
							wts_n = 1'b0;
						end
					end
					default: begin
						pos_n = '0;
					end
				endcase
			end
		end
	end

	// block store
	sdsr_ram #(
		.WIDTH (8),
		.DEPTH (STORE_BYTES)
	) u_store (
		.clk   (clk),
		.we    (clr_q || (acc && mem_wr)),
		.waddr (clr_q ? clr_addr_q : addr),
		.wdata (clr_q ? BYTE_ZERO : b),
		.re    (acc && mem_rd),
		.raddr (addr),
		.rdata (rd_data)
	);

	// clearing sweep after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == STORE_AW'(STORE_BYTES - 1)) begin
				clr_q <= 1'b0;
			end
		end
	end

	// card state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_delay_q <= READY_DELAY_RESET;
			countdown_q   <= READY_DELAY_RESET;
			mode_q        <= MODE_POWERUP;
			pos_q         <= '0;
			app_q         <= 1'b0;
			wts_q         <= 1'b0;
		end else if (cfg_wr) begin
			ready_delay_q <= pwdata[3:0];
			countdown_q   <= pwdata[3:0];
		end else if (acc) begin
			countdown_q <= countdown_n;
			mode_q      <= mode_n;
			pos_q       <= pos_n;
			app_q       <= app_n;
			wts_q       <= wts_n;
		end
	end

	// command frame bytes
	always_ff @(posedge clk) begin
		if (acc) begin
			frame_q <= frame_n;
		end
	end

	// pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (acc) begin
				valid_s1 <= 1'b1;
			end else if (adv1) begin
				valid_s1 <= 1'b0;
			end
			if (adv1) begin
				valid_s2 <= 1'b1;
			end else if (miso.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// pipeline payload
	always_ff @(posedge clk) begin
		if (acc) begin
			resp_s1 <= resp;
			mem_s1  <= mem_rd;
		end
		if (adv1) begin
			byte_s2 <= mem_s1 ? rd_data : resp_s1;
		end
	end

endmodule

`default_nettype wire

>>> src/sdsr_ram.sv
// generic simple dual port ram, one write and one registered read port
// no dependencies
`default_nettype none

module sdsr_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port, holds when idle
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire
